>>> hdl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, always checked.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/swng_pkg.sv
// Package for the square wave note generator: widths, reset values, shared types.
`default_nettype none
package swng_pkg;
    localparam int FREQ_W     = 12;
    localparam int DUR_W      = 4;
    localparam int SCALE_W    = 16;
    localparam int HALF_W     = 16;
    localparam int PERIODS_W  = 14;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    localparam logic [SCALE_W-1:0] TONE_SCALE_RESET = 16'd50000;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;
endpackage
`default_nettype wire

>>> hdl/square_wave_note_generator.sv
// Top level of the square wave note generator: sequencer, tone state and stream ports.
`default_nettype none
// Buzzer tone generator. Each input transfer is a load (tuser 0: frequency and
// duration in tdata) or a time-base tick (tuser 1), and yields exactly one output
// transfer carrying the pin level, a busy flag and tlast on the transfer where the
// note ends. A tick's result is registered in the cycle after acceptance. A load
// passes through ST_START and ST_DIV: the half period tone_scale / frequency comes
// from a bit-serial divider that retires one quotient bit per cycle. Input is
// taken only when the sequencer is idle and the output register is empty or
// being drained in the same cycle. tone_scale is to be written through the
// configuration port while idle (not enforced by the block) and resets to 50000.
module square_wave_note_generator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [swng_pkg::SCALE_W-1:0]      i_cfg_wr_data,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // [11:0] frequency, [15:12] duration
    input  wire logic [swng_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] mode
    input  wire logic                              s_axis_tuser,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] tone_level, [1] busy_res, [7:2] zero
    output      logic [swng_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // note_done
    output      logic                              m_axis_tlast
);
    import swng_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_START, ST_DIV} t_state;

    t_state                r_state, n_state;
    logic [SCALE_W-1:0]    r_scale, n_scale;
    logic [HALF_W-1:0]     r_half, n_half;
    logic [HALF_W-1:0]     r_phase_cnt, n_phase_cnt;
    logic [PERIODS_W-1:0]  r_periods, n_periods;
    logic                  r_phase_high, n_phase_high;
    logic                  r_playing, n_playing;
    logic [FREQ_W-1:0]     r_freq, n_freq;
    logic                  r_ovalid, n_ovalid;
    logic                  r_level, n_level;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    logic                  in_xfer;
    logic [IN_DATA_W-1:0]  product;
    logic [HALF_W-1:0]     cnt_inc;
    logic [PERIODS_W-1:0]  periods_dec;
    logic [HALF_W-1:0]     quot_eff;
    t_div_stat             div_stat;
    logic [HALF_W-1:0]     div_q;

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign product       = {{(IN_DATA_W-FREQ_W){1'b0}}, s_axis_tdata[FREQ_W-1:0]}
                         * {{(IN_DATA_W-DUR_W){1'b0}}, s_axis_tdata[FREQ_W +: DUR_W]};
    assign cnt_inc       = r_phase_cnt + 1'b1;
    assign periods_dec   = r_periods - 1'b1;
    assign quot_eff      = (r_freq == '0) ? '0 : div_q;

    swng_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_START),
        .i_dividend (r_scale),
        .i_divisor  (r_freq),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state      = r_state;
        n_scale      = i_cfg_wr_en ? i_cfg_wr_data : r_scale;
        n_half       = r_half;
        n_phase_cnt  = r_phase_cnt;
        n_periods    = r_periods;
        n_phase_high = r_phase_high;
        n_playing    = r_playing;
        n_freq       = r_freq;
        n_ovalid     = r_ovalid && !m_axis_tready;
        n_level      = r_level;
        n_busy       = r_busy;
        n_done       = r_done;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_axis_tuser == MODE_LOAD) begin
                        n_freq      = s_axis_tdata[FREQ_W-1:0];
                        n_periods   = product[IN_DATA_W-1:2];
                        n_phase_cnt = '0;
                        n_state     = ST_START;
                    end else begin
                        n_ovalid = 1'b1;
                        n_level  = r_playing && r_phase_high;
                        n_done   = 1'b0;
                        if (r_playing) begin
                            n_phase_cnt = cnt_inc;
                            if (cnt_inc >= r_half) begin
                                n_phase_cnt = '0;
                                if (r_phase_high) begin
                                    n_phase_high = 1'b0;
                                end else begin
                                    n_periods = periods_dec;
                                    if (periods_dec == '0) begin
                                        n_playing = 1'b0;
                                        n_done    = 1'b1;
                                    end else begin
                                        n_phase_high = 1'b1;
                                    end
                                end
                            end
                        end
                        n_busy = n_playing;
                    end
                end
            end
            ST_START: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state  = ST_IDLE;
                    n_half   = quot_eff;
                    n_ovalid = 1'b1;
                    n_level  = 1'b0;
                    if (quot_eff == '0 || r_periods == '0) begin
                        n_playing    = 1'b0;
                        n_phase_high = 1'b0;
                        n_periods    = '0;
                        n_done       = 1'b1;
                        n_busy       = 1'b0;
                    end else begin
                        n_playing    = 1'b1;
                        n_phase_high = 1'b1;
                        n_done       = 1'b0;
                        n_busy       = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scale      <= TONE_SCALE_RESET;
            r_half       <= '0;
            r_phase_cnt  <= '0;
            r_periods    <= '0;
            r_phase_high <= 1'b0;
            r_playing    <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_scale      <= n_scale;
            r_half       <= n_half;
            r_phase_cnt  <= n_phase_cnt;
            r_periods    <= n_periods;
            r_phase_high <= n_phase_high;
            r_playing    <= n_playing;
            r_ovalid     <= n_ovalid;
        end
        r_freq  <= n_freq;
        r_level <= n_level;
        r_busy  <= n_busy;
        r_done  <= n_done;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_busy, r_level};
    assign m_axis_tlast  = r_done;
endmodule
`default_nettype wire

>>> hdl/swng_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module swng_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [swng_pkg::SCALE_W-1:0]  i_dividend,
    input  wire logic [swng_pkg::FREQ_W-1:0]   i_divisor,
    output      swng_pkg::t_div_stat           o_stat,
    output      logic [swng_pkg::HALF_W-1:0]   o_quotient
);
    import swng_pkg::*;

    localparam int CNT_W = $clog2(SCALE_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SCALE_W - 1);

    logic [SCALE_W-1:0] r_q, n_q;
    logic [FREQ_W-1:0]  r_rem, n_rem;
    logic [FREQ_W-1:0]  r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy, r_done;
    logic [FREQ_W:0]    rem_sh, diff;

    always_comb begin
        rem_sh = {r_rem, r_q[SCALE_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        if (rem_sh >= {1'b0, r_div}) begin
            n_rem = diff[FREQ_W-1:0];
            n_q   = {r_q[SCALE_W-2:0], 1'b1};
        end else begin
            n_rem = rem_sh[FREQ_W-1:0];
            n_q   = {r_q[SCALE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_q;
endmodule
`default_nettype wire

>>> hdl/swng_checker.sv
// Port-level checker for the square wave note generator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module swng_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [swng_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire logic                              m_axis_tlast
);
    import swng_pkg::*;

    // stalled result holds
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output changed")
    // a finished note is never reported busy
    `ASSERT_RST(a_done_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[1], "note_done with busy set")
    // a note never ends on a transfer with the pin level high
    `ASSERT_RST(a_done_low, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tlast, "note_done on a high tick")
    // a load holds off input while the divider runs
    `ASSERT_RST(a_load_stall, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_LOAD |=> !s_axis_tready, "input taken during load")
    // reset empties the output register
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
endmodule

bind square_wave_note_generator swng_checker u_swng_checker (.*);
`default_nettype wire

>>> verif/tone_checker.sv
`timescale 1ns / 100ps
// Checker for the note generator: predicts each output transfer from the input side and compares.
module tone_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [swng_pkg::SCALE_W-1:0]    i_cfg_wr_data,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_ready,
    // [11:0] frequency, [15:12] duration
    input  wire logic [swng_pkg::IN_DATA_W-1:0]  i_in_data,
    // [0] mode
    input  wire logic                            i_in_user,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_ready,
    // [0] tone_level, [1] busy_res, [7:2] zero
    input  wire logic [swng_pkg::OUT_DATA_W-1:0] i_out_data,
    // note_done
    input  wire logic                            i_out_last,
    output int                                   o_errors,
    output int                                   o_pending
);
    import swng_pkg::*;

    typedef struct packed {
        logic level;
        logic busy;
        logic done;
    } t_tone_res;

    t_tone_res            predicted_q[$];
    logic [SCALE_W-1:0]   scale = TONE_SCALE_RESET;
    logic [HALF_W-1:0]    half_period;
    logic [HALF_W-1:0]    phase_count;
    logic [PERIODS_W-1:0] periods_left;
    logic                 phase_high;
    logic                 playing;
    int                   err_cnt = 0;

    task automatic advance_note(input logic mode, input logic [FREQ_W-1:0] freq,
                                input logic [DUR_W-1:0] dur);
        t_tone_res   res;
        logic [31:0] prod;
        res = '0;
        if (mode == MODE_LOAD) begin
            half_period = (freq != 0) ? HALF_W'(32'(scale) / 32'(freq)) : '0;
            prod = 32'(freq) * 32'(dur);
            periods_left = PERIODS_W'(prod >> 2);
            phase_count = '0;
            if (half_period == 0 || periods_left == 0) begin
                playing = 1'b0;
                phase_high = 1'b0;
                periods_left = '0;
                res.done = 1'b1;
            end else begin
                playing = 1'b1;
                phase_high = 1'b1;
            end
        end else if (playing) begin
            res.level = phase_high;
            phase_count = phase_count + 1'b1;
            if (phase_count >= half_period) begin
                phase_count = '0;
                if (phase_high) begin
                    phase_high = 1'b0;
                end else begin
                    periods_left = periods_left - 1'b1;
                    if (periods_left == 0) begin
                        playing = 1'b0;
                        res.done = 1'b1;
                    end else begin
                        phase_high = 1'b1;
                    end
                end
            end
        end
        res.busy = playing;
        predicted_q.push_back(res);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t tone_checker: %s mismatch, expected %0h actual %0h",
                     $time, name, want, got);
        end
    endtask

    task automatic check_transfer(input logic [OUT_DATA_W-1:0] data, input logic last);
        t_tone_res want;
        if (predicted_q.size() == 0) begin
            err_cnt++;
            $display("%0t tone_checker: unexpected transfer, expected none actual %0h/%0b",
                     $time, data, last);
        end else begin
            want = predicted_q.pop_front();
            compare_field("tone_level", 8'(want.level), 8'(data[0]));
            compare_field("busy_res", 8'(want.busy), 8'(data[1]));
            compare_field("note_done", 8'(want.done), 8'(last));
            compare_field("pad", 8'h00, 8'(data[OUT_DATA_W-1:2]));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scale = TONE_SCALE_RESET;
            half_period = '0;
            phase_count = '0;
            periods_left = '0;
            phase_high = 1'b0;
            playing = 1'b0;
            predicted_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_transfer(i_out_data, i_out_last);
            end
            if (i_in_valid && i_in_ready) begin
                advance_note(i_in_user, i_in_data[FREQ_W-1:0],
                             i_in_data[FREQ_W+DUR_W-1:FREQ_W]);
            end
            if (i_cfg_wr_en) begin
                scale = i_cfg_wr_data;
            end
        end
        o_errors <= err_cnt;
        o_pending <= predicted_q.size();
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the note generator: clock, reset, stimulus, ready pattern and verdict.
module tb_top;
    import swng_pkg::*;

    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [SCALE_W-1:0]    cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    int                    errors;
    int                    pending;
    int                    items_sent = 0;
    logic [SCALE_W-1:0]    cur_scale = TONE_SCALE_RESET;
    bit                    no_idle = 1'b0;
    bit                    hold_req = 1'b0;

    square_wave_note_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    tone_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (s_tvalid),
        .i_in_ready    (s_tready),
        .i_in_data     (s_tdata),
        .i_in_user     (s_tuser),
        .i_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .i_out_data    (m_tdata),
        .i_out_last    (m_tlast),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic mode, input logic [FREQ_W-1:0] freq,
                             input logic [DUR_W-1:0] dur);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {dur, freq};
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, FREQ_W'($urandom_range(0, 4095)), DUR_W'($urandom_range(0, 15)));
    endtask

    task automatic set_scale(input logic [SCALE_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        cur_scale = value;
    endtask

    // load a note, then tick it through to the end or cut it short; sometimes send one random item instead
    task automatic send_note_run();
        int          r;
        int          lim;
        int          half;
        int          per;
        int          needed;
        int          ticks;
        logic [11:0] freq;
        logic [3:0]  dur;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            send_item(1'($urandom_range(0, 1)), FREQ_W'($urandom_range(0, 4095)),
                      DUR_W'($urandom_range(0, 15)));
        end else begin
            lim = (cur_scale < 4095) ? int'(cur_scale) : 4095;
            r = $urandom_range(0, 99);
            if (r < 10) freq = '0;
            else if (r < 35) freq = FREQ_W'($urandom_range(0, 4095));
            else freq = FREQ_W'($urandom_range(1, lim));
            dur = DUR_W'($urandom_range(0, 15));
            half = (freq != 0) ? int'(cur_scale) / int'(freq) : 0;
            per = (int'(freq) * int'(dur)) / 4;
            needed = (half != 0 && per != 0) ? 2 * half * per : 0;
            if (needed <= 300) begin
                if ($urandom_range(0, 3) == 0) ticks = $urandom_range(0, needed);
                else ticks = needed + $urandom_range(0, 3);
            end else begin
                ticks = $urandom_range(1, 40);
            end
            send_item(MODE_LOAD, freq, dur);
            repeat (ticks) send_tick();
        end
    endtask

    task automatic run_phase(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) send_note_run();
    endtask

    initial begin
        forever begin
            int off;
            int on;
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                off = pick_gap();
                if (off > 0) begin
                    m_tready <= 1'b0;
                    repeat (off) @(posedge i_clk);
                end
                m_tready <= 1'b1;
                on = no_idle ? 1 : $urandom_range(1, 8);
                repeat (on) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle tick, zero frequency, zero period count, extremes, reload
        send_tick();
        send_item(MODE_LOAD, 12'd0, 4'd5);
        send_item(MODE_LOAD, 12'd4095, 4'd0);
        send_item(MODE_LOAD, 12'd4095, 4'd15);
        repeat (13) send_tick();
        send_item(MODE_LOAD, 12'd1, 4'd15);
        repeat (3) send_tick();
        send_item(MODE_LOAD, 12'd2048, 4'd1);
        send_tick();
        send_item(MODE_LOAD, 12'd1, 4'd3);
        send_tick();

        run_phase(300);

        set_scale(16'd1);
        no_idle = 1'b1;
        run_phase(200);
        no_idle = 1'b0;

        set_scale(16'd65535);
        run_phase(300);

        set_scale(SCALE_W'($urandom_range(8, 120)));
        hold_req = 1'b1;
        run_phase(600);

        set_scale(SCALE_W'($urandom_range(1, 65535)));
        run_phase(300);

        set_scale(SCALE_W'($urandom_range(8, 200)));
        run_phase(300);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/swng_pkg.sv
hdl/swng_div.sv
hdl/square_wave_note_generator.sv
hdl/swng_checker.sv
verif/tone_checker.sv
verif/tb_top.sv
